@@ src/vpwr_pkg.sv @@
`timescale 1ns / 1ps

package vpwr_pkg;

   // Default plane depth in bytes. Must be a power of two (256 to 65536).
   localparam int PLANE_BYTES_DEF = 65536;

   localparam int NUM_PLANES = 4;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = NUM_PLANES * BYTE_W;

   // Request commands
   localparam logic [1:0] CMD_READ       = 2'd0;
   localparam logic [1:0] CMD_WRITE_BYTE = 2'd1;
   localparam logic [1:0] CMD_WRITE_WORD = 2'd2;

   // Write modes
   localparam logic [1:0] WMODE_ALU    = 2'd0;
   localparam logic [1:0] WMODE_LATCH  = 2'd1;
   localparam logic [1:0] WMODE_EXPAND = 2'd2;
   localparam logic [1:0] WMODE_MASKED = 2'd3;

   // Logic functions
   localparam logic [1:0] LFN_REPLACE = 2'd0;
   localparam logic [1:0] LFN_AND     = 2'd1;
   localparam logic [1:0] LFN_OR      = 2'd2;
   localparam logic [1:0] LFN_XOR     = 2'd3;

   // CSR indexes
   localparam logic [2:0] REG_PLANE_WR_EN = 3'd0;
   localparam logic [2:0] REG_SR_VALUE    = 3'd1;
   localparam logic [2:0] REG_SR_ENABLE   = 3'd2;
   localparam logic [2:0] REG_ROTATE      = 3'd3;
   localparam logic [2:0] REG_LOGIC_FN    = 3'd4;
   localparam logic [2:0] REG_WRITE_MODE  = 3'd5;
   localparam logic [2:0] REG_READ_PLANE  = 3'd6;
   localparam logic [2:0] REG_BIT_MASK    = 3'd7;

   typedef struct packed {
      logic [3:0] plane_wr_en;
      logic [3:0] set_reset_value;
      logic [3:0] set_reset_enable;
      logic [2:0] rotate_count;
      logic [1:0] logic_function;
      logic [1:0] write_mode;
      logic [1:0] read_plane;
      logic [7:0] bit_mask;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      plane_wr_en:      4'hF,
      set_reset_value:  4'h0,
      set_reset_enable: 4'h0,
      rotate_count:     3'd0,
      logic_function:   LFN_REPLACE,
      write_mode:       WMODE_ALU,
      read_plane:       2'd0,
      bit_mask:         8'hFF
   };

endpackage

@@ src/vpwr_mem.sv @@
`timescale 1ns / 1ps

// Plane memory: one 32-bit word per offset, one byte lane per plane.
module vpwr_mem #(
   parameter int DEPTH  = vpwr_pkg::PLANE_BYTES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [vpwr_pkg::NUM_PLANES-1:0]  wr_be,
   input  logic [vpwr_pkg::WORD_W-1:0]      wr_data,
   input  logic                             rd_en,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [vpwr_pkg::WORD_W-1:0]      rd_data
);
   import vpwr_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            if (wr_be[p]) begin
               mem[wr_addr][p*BYTE_W +: BYTE_W] <= wr_data[p*BYTE_W +: BYTE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/vpwr_wdp.sv @@
`timescale 1ns / 1ps

// Write datapath: builds the new byte of every plane from the data byte,
// the plane latches and the graphics controller registers.
module vpwr_wdp (
   input  vpwr_pkg::cfg_type                cfg,
   input  logic [vpwr_pkg::WORD_W-1:0]      latches,
   input  logic [vpwr_pkg::BYTE_W-1:0]      value,
   output logic [vpwr_pkg::WORD_W-1:0]      wr_data
);
   import vpwr_pkg::*;

   logic [2*BYTE_W-1:0] rot_wide;
   logic [BYTE_W-1:0]   rotated;

   assign rot_wide = {value, value} >> cfg.rotate_count;
   assign rotated  = rot_wide[BYTE_W-1:0];

   always_comb begin
      logic [BYTE_W-1:0] lat;
      logic [BYTE_W-1:0] fill;
      logic [BYTE_W-1:0] src;
      logic [BYTE_W-1:0] alu;
      logic [BYTE_W-1:0] sel;
      logic [BYTE_W-1:0] res;
      wr_data = '0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         lat  = latches[p*BYTE_W +: BYTE_W];
         fill = {BYTE_W{cfg.set_reset_value[p]}};
         if (cfg.write_mode == WMODE_EXPAND) begin
            src = {BYTE_W{value[p]}};
         end else if (cfg.set_reset_enable[p]) begin
            src = fill;
         end else begin
            src = rotated;
         end
         case (cfg.logic_function)
            LFN_AND: alu = src & lat;
            LFN_OR:  alu = src | lat;
            LFN_XOR: alu = src ^ lat;
            default: alu = src;
         endcase
         sel = rotated & cfg.bit_mask;
         case (cfg.write_mode)
            WMODE_LATCH:  res = lat;
            WMODE_MASKED: res = (fill & sel) | (lat & ~sel);
            default:      res = (alu & cfg.bit_mask) | (lat & ~cfg.bit_mask);
         endcase
         wr_data[p*BYTE_W +: BYTE_W] = res;
      end
   end

endmodule

@@ src/vga_planar_write_read_unit.sv @@
`timescale 1ns / 1ps

// Four-plane video memory behind a graphics controller.
// Request channel (req_*): cmd, offset, data under valid/ready. A read loads
// the four plane latches from the offset and returns one byte on the
// response channel (rsp_*); byte and word writes return nothing.
// CSR port (csr_*): the eight controller registers, to be written only while
// idle; the block does not enforce this. A read's byte goes through the
// registered memory output into the output register behind rsp_valid.
// Byte writes go one per cycle while no read or clearing holds the request
// channel; a word write takes both bytes through the single memory write
// port. A read waits until the last read's registered memory output has
// landed in the latches. A write right after a read sees the new latches by
// forwarding. Reset: controller registers return to defaults, latches
// clear, and a clearing pass zeroes every offset, one offset per cycle, with
// req_ready low throughout. Stall: a waiting response is held in the output
// register; a read waits in the execute stage until it is free.
module vga_planar_write_read_unit #(
   parameter int PLANE_BYTES = vpwr_pkg::PLANE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_offset,
   input  logic [15:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import vpwr_pkg::*;

   localparam int ADDR_W = $clog2(PLANE_BYTES);

   // Controller registers
   cfg_type cfg_ff, cfg_in;

   // Execute stage: the request being worked on
   logic        ex_valid_ff, ex_valid_in;
   logic [1:0]  ex_cmd_ff, ex_cmd_in;
   logic [15:0] ex_offset_ff, ex_offset_in;
   logic [15:0] ex_data_ff, ex_data_in;
   logic        phase_ff, phase_in;    // high byte of a word write

   // Latch load and response
   logic                lat_load_ff, lat_load_in;
   logic [WORD_W-1:0]   latch_ff, latch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;

   // Clearing pass
   logic                clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   logic                ex_done;
   logic                ex_write;
   logic                rd_issue;
   logic                rd_ok;
   logic [15:0]         ex_addr_full;
   logic [ADDR_W-1:0]   ex_addr;
   logic [BYTE_W-1:0]   ex_value;
   logic [WORD_W-1:0]   lat_eff;
   logic [WORD_W-1:0]   mem_q;
   logic [WORD_W-1:0]   wdp_data;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [NUM_PLANES-1:0] mem_be;
   logic [WORD_W-1:0]   mem_wdata;

   // ---- CSR writes ----
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PLANE_WR_EN: cfg_in.plane_wr_en     = csr_wdata[3:0];
            REG_SR_VALUE:   cfg_in.set_reset_value  = csr_wdata[3:0];
            REG_SR_ENABLE:  cfg_in.set_reset_enable = csr_wdata[3:0];
            REG_ROTATE:     cfg_in.rotate_count     = csr_wdata[2:0];
            REG_LOGIC_FN:   cfg_in.logic_function   = csr_wdata[1:0];
            REG_WRITE_MODE: cfg_in.write_mode       = csr_wdata[1:0];
            REG_READ_PLANE: cfg_in.read_plane       = csr_wdata[1:0];
            REG_BIT_MASK:   cfg_in.bit_mask         = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // ---- Execute stage control ----
   // A read may issue only if the output register is free by the time the
   // memory data lands, and no earlier read is still loading.
   assign rd_ok = !lat_load_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ex_done  = 1'b0;
      ex_write = 1'b0;
      rd_issue = 1'b0;
      if (ex_valid_ff) begin
         unique case (ex_cmd_ff)
            CMD_READ: begin
               ex_done  = rd_ok;
               rd_issue = rd_ok;
            end
            CMD_WRITE_BYTE: begin
               ex_write = 1'b1;
               ex_done  = 1'b1;
            end
            CMD_WRITE_WORD: begin
               ex_write = 1'b1;
               ex_done  = phase_ff;
            end
            default: ex_done = 1'b1;   // unused command, dropped
         endcase
      end
   end

   assign req_ready = !clr_busy_ff && (!ex_valid_ff || ex_done);

   always_comb begin
      ex_valid_in  = ex_valid_ff;
      ex_cmd_in    = ex_cmd_ff;
      ex_offset_in = ex_offset_ff;
      ex_data_in   = ex_data_ff;
      phase_in     = phase_ff;
      if (ex_done) begin
         ex_valid_in = 1'b0;
         phase_in    = 1'b0;
      end else if (ex_write) begin
         phase_in = 1'b1;   // low byte of a word written, high byte next
      end
      if (req_valid && req_ready) begin
         ex_valid_in  = 1'b1;
         ex_cmd_in    = req_cmd;
         ex_offset_in = req_offset;
         ex_data_in   = req_data;
      end
   end

   // offset+1 wraps at 16 bits, then the plane depth takes the low bits
   assign ex_addr_full = ex_offset_ff + {15'd0, phase_ff};
   assign ex_addr      = ex_addr_full[ADDR_W-1:0];
   assign ex_value     = phase_ff ? ex_data_ff[15:8] : ex_data_ff[7:0];

   // Latches forwarded straight from the memory in the load cycle
   assign lat_eff  = lat_load_ff ? mem_q : latch_ff;
   assign latch_in = lat_eff;

   vpwr_wdp u_wdp (
      .cfg     (cfg_ff),
      .latches (lat_eff),
      .value   (ex_value),
      .wr_data (wdp_data)
   );

   // Clearing pass owns the write port until it is done
   assign mem_we    = clr_busy_ff || ex_write;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : ex_addr;
   assign mem_be    = clr_busy_ff ? {NUM_PLANES{1'b1}} : cfg_ff.plane_wr_en;
   assign mem_wdata = clr_busy_ff ? '0 : wdp_data;

   assign clr_addr_in = clr_busy_ff ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != {ADDR_W{1'b1}});

   vpwr_mem #(
      .DEPTH  (PLANE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_be   (mem_be),
      .wr_data (mem_wdata),
      .rd_en   (rd_issue),
      .rd_addr (ex_addr),
      .rd_data (mem_q)
   );

   // ---- Response ----
   assign lat_load_in  = rd_issue;
   assign rsp_valid_in = lat_load_ff || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = lat_load_ff ? mem_q[{cfg_ff.read_plane, 3'b000} +: BYTE_W]
                                     : rsp_data_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ---- Registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         ex_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         lat_load_ff  <= 1'b0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         ex_valid_ff  <= ex_valid_in;
         phase_ff     <= phase_in;
         lat_load_ff  <= lat_load_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_cmd_ff    <= ex_cmd_in;
      ex_offset_ff <= ex_offset_in;
      ex_data_ff   <= ex_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ---- Assertions ----
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("request accepted during memory clearing");

   a_load_finds_free_output: assert property (@(posedge clock) disable iff (reset)
      lat_load_ff |-> !rsp_valid_ff)
      else $error("latch load would overwrite a pending response");

   a_single_read_in_flight: assert property (@(posedge clock) disable iff (reset)
      rd_issue |=> !rd_issue)
      else $error("read issued while another read is loading");

   a_phase_only_for_word: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (ex_valid_ff && ex_cmd_ff == CMD_WRITE_WORD))
      else $error("high byte phase outside a word write");

   a_no_write_during_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !ex_valid_ff)
      else $error("execute stage busy during memory clearing");

endmodule
